@@ rtl/modular_exponentiation_core_macros.svh @@
// Assertion helpers for the modular exponentiation core.
// All checks sample on clk and are off while rst is high.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mexp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // Operand widths
  localparam int MOD_WIDTH = 31;
  localparam int EXP_WIDTH = 63;
  localparam int CNT_WIDTH = $clog2(MOD_WIDTH);

  // Modulus after reset
  localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(1000000007);

  // Fermat inverse uses modulus minus this
  localparam logic [MOD_WIDTH-1:0] INV_OFFSET = MOD_WIDTH'(2);

  // Smallest usable modulus
  localparam logic [MOD_WIDTH-1:0] MOD_MIN = MOD_WIDTH'(2);

  // Opcodes
  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } mexp_state_t;

endpackage

`default_nettype wire

@@ rtl/modular_exponentiation_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_core_macros.svh"

// Computes base ** exponent mod modulus by right-to-left square and multiply
// (opcode 1: base ** (modulus - 2), the Fermat inverse for a prime modulus).
// All arithmetic runs on one shared bit-serial modular multiplier, one
// multiplier bit per cycle with two conditional subtracts. A word is
// accepted and its base reduced, then per exponent bit up to its highest set
// bit the core scans the bit, multiplies if the bit is set and squares; a
// closing scan and a finish step end the word. A modulus below two goes
// straight from accept to finish (result 0). req_stall stays high while a
// word is in work; the result sits in an output register, so the next word
// is taken while it waits on rsp_stall.
// The modulus is written through modulus_we / modulus_data; the user must
// write it only while idle, the core itself does not enforce this.
module modular_exponentiation_core
  import mexp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 modulus_we,
  input  wire logic [MOD_WIDTH-1:0] modulus_data,
  // request channel
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 opcode,
  input  wire logic [MOD_WIDTH-1:0] base,
  input  wire logic [EXP_WIDTH-1:0] exponent,
  // response channel
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [MOD_WIDTH-1:0]      result
);

  mexp_state_t state, state_next;

  logic [MOD_WIDTH-1:0] modulus;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] sq;
  logic [EXP_WIDTH-1:0] exp_rem;

  // shared multiplier: mul_r = (mul_r * 2 + bit * op_a) mod modulus
  logic [MOD_WIDTH-1:0] op_a;
  logic [MOD_WIDTH-1:0] op_b;
  logic [MOD_WIDTH-1:0] mul_r;
  logic [CNT_WIDTH-1:0] mul_cnt;

  logic [MOD_WIDTH:0]   mod_ext;
  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   add;
  logic [MOD_WIDTH:0]   add_red;
  logic [MOD_WIDTH-1:0] mul_r_next;
  logic                 mul_busy;
  logic                 mul_last;

  logic req_accept;
  logic rsp_load;

  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;

  // one modular step of the multiplier
  always_comb begin
    mod_ext    = {1'b0, modulus};
    dbl        = {mul_r, 1'b0};
    dbl_red    = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    add        = dbl_red + (op_b[MOD_WIDTH-1] ? {1'b0, op_a} : '0);
    add_red    = (add >= mod_ext) ? add - mod_ext : add;
    mul_r_next = add_red[MOD_WIDTH-1:0];
  end

  assign mul_busy = (state == ST_REDUCE) || (state == ST_MUL) || (state == ST_SQR);
  assign mul_last = (mul_cnt == CNT_WIDTH'(MOD_WIDTH - 1));

  // sequencer: next state and output load
  always_comb begin
    state_next = state;
    rsp_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          state_next = (modulus < MOD_MIN) ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (exp_rem == '0) begin
          state_next = ST_FINISH;
        end else if (exp_rem[0]) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mul_last) state_next = ST_SQR;
      end
      ST_SQR: begin
        if (mul_last) state_next = ST_SCAN;
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      modulus   <= MOD_RESET;
      rsp_valid <= 1'b0;
      mul_cnt   <= '0;
    end else begin
      state <= state_next;
      if (modulus_we) modulus <= modulus_data;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (mul_busy) begin
        mul_cnt <= mul_last ? '0 : mul_cnt + CNT_WIDTH'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // multiplier step; a finished multiply reloads straight for the square
    if (mul_busy) begin
      if (state == ST_MUL && mul_last) begin
        mul_r <= '0;
        op_b  <= sq;
      end else begin
        mul_r <= mul_r_next;
        op_b  <= {op_b[MOD_WIDTH-2:0], 1'b0};
      end
    end
    if (rsp_load) result <= acc;

    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          // acc = 1 mod m, or 0 when the modulus is unusable
          acc     <= (modulus < MOD_MIN) ? '0 : MOD_WIDTH'(1);
          exp_rem <= (opcode == OP_INVERSE) ? EXP_WIDTH'(modulus - INV_OFFSET) : exponent;
          // base mod m as 1 * base on the multiplier
          op_a    <= MOD_WIDTH'(1);
          op_b    <= base;
          mul_r   <= '0;
        end
      end
      ST_REDUCE: begin
        if (mul_last) sq <= mul_r_next;
      end
      ST_SCAN: begin
        mul_r <= '0;
        op_b  <= sq;
        op_a  <= exp_rem[0] ? acc : sq;
      end
      ST_MUL: begin
        if (mul_last) begin
          acc  <= mul_r_next;
          op_a <= sq;
        end
      end
      ST_SQR: begin
        if (mul_last) begin
          sq      <= mul_r_next;
          exp_rem <= exp_rem >> 1;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // checks
  `MEXP_ASSERT_IMP(a_scan_cnt_clear, state == ST_SCAN, mul_cnt == '0,
                   "multiplier count not cleared at scan")
  `MEXP_ASSERT_NXT(a_accept_path, req_accept, state == ST_REDUCE || state == ST_FINISH,
                   "accepted word did not start work")
  `MEXP_ASSERT_NXT(a_sqr_shift, state == ST_SQR && mul_last,
                   state == ST_SCAN && exp_rem == ($past(exp_rem) >> 1),
                   "exponent not shifted after squaring")
  `MEXP_ASSERT_IMP(a_rsp_source, $rose(rsp_valid), $past(state) == ST_FINISH,
                   "result shown without finishing")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import mexp_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 50;
  localparam logic [MOD_WIDTH-1:0] MOD_MAX = '1;
  localparam logic [EXP_WIDTH-1:0] EXP_MAX = '1;

  // Tracks the modulus, predicts each result word and checks it in order
  class mexp_scoreboard_t;
    logic [MOD_WIDTH-1:0] modulus;
    logic [MOD_WIDTH-1:0] pending_results[$];
    int words_in;
    int words_checked;
    int mismatches;

    function new();
      modulus = MOD_RESET;
      words_in = 0;
      words_checked = 0;
      mismatches = 0;
    endfunction

    // Right-to-left square and multiply, every product reduced at once
    function logic [MOD_WIDTH-1:0] power_mod(logic [MOD_WIDTH-1:0] b,
                                             logic [EXP_WIDTH-1:0] e);
      bit [63:0] m;
      bit [63:0] acc;
      bit [63:0] sq;
      if (modulus < MOD_MIN) return '0;
      m = 64'(modulus);
      acc = 64'd1 % m;
      sq = 64'(b) % m;
      for (int i = 0; i < EXP_WIDTH; i++) begin
        if (e[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      return acc[MOD_WIDTH-1:0];
    endfunction

    function void note_request(logic op, logic [MOD_WIDTH-1:0] b,
                               logic [EXP_WIDTH-1:0] e);
      logic [EXP_WIDTH-1:0] pw;
      // inverse ignores the exponent field and uses modulus minus two
      pw = (op == OP_INVERSE) ? EXP_WIDTH'(modulus - INV_OFFSET) : e;
      pending_results = {pending_results, power_mod(b, pw)};
      words_in++;
    endfunction

    function void check_result(logic [MOD_WIDTH-1:0] got);
      logic [MOD_WIDTH-1:0] want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding: result actual %0d", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      words_checked++;
      if (got !== want) begin
        $error("result mismatch: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic modulus_we = 1'b0;
  logic [MOD_WIDTH-1:0] modulus_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  logic opcode = OP_POWER;
  logic [MOD_WIDTH-1:0] base = '0;
  logic [EXP_WIDTH-1:0] exponent = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [MOD_WIDTH-1:0] result;

  mexp_scoreboard_t sb = new();
  bit hold_due = 1'b0;
  int mod_settings = 0;

  modular_exponentiation_core uut (
    .clk(clk),
    .rst(rst),
    .modulus_we(modulus_we),
    .modulus_data(modulus_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .base(base),
    .exponent(exponent),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, some zero, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [EXP_WIDTH-1:0] rand_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return EXP_MAX;
      2, 3: return EXP_WIDTH'($urandom_range(0, 40));
      4: return EXP_WIDTH'(1) << $urandom_range(0, EXP_WIDTH - 1);
      default: return EXP_WIDTH'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [MOD_WIDTH-1:0] rand_base(logic [MOD_WIDTH-1:0] m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MOD_MAX;
      2: return m;
      3: return m - 1'b1;
      4: return MOD_WIDTH'($urandom_range(0, 20));
      default: return MOD_WIDTH'($urandom());
    endcase
  endfunction

  // Offer one request word and hold it until accepted
  task automatic send_word(logic op, logic [MOD_WIDTH-1:0] b,
                           logic [EXP_WIDTH-1:0] e, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    base <= b;
    exponent <= e;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(op, b, e);
  endtask

  // Close a phase: stop offering, wait for every result word
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(logic [MOD_WIDTH-1:0] value);
    modulus_we <= 1'b1;
    modulus_data <= value;
    @(posedge clk);
    modulus_we <= 1'b0;
    sb.modulus = value;
    mod_settings++;
  endtask

  task automatic random_words(int count);
    repeat (count) begin
      send_word(($urandom_range(0, 3) == 0) ? OP_INVERSE : OP_POWER,
                rand_base(sb.modulus), rand_exponent());
    end
    drain();
  endtask

  // Response side: checks accepted words, alternates free runs and stalls
  initial begin : rx_side
    int stall_left;
    int go_left;
    stall_left = 0;
    go_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_result(result);
      if (hold_due) begin
        hold_due = 1'b0;
        stall_left = HOLD_CYCLES;
        go_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (go_left > 0) begin
        go_left--;
        rsp_stall <= 1'b0;
      end else begin
        go_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 12);
        stall_left = pick_gap();
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset modulus: field extremes and both opcodes
    send_word(OP_POWER, '0, '0);
    send_word(OP_POWER, '0, EXP_WIDTH'(5));
    send_word(OP_POWER, MOD_MAX, EXP_MAX);
    send_word(OP_POWER, MOD_WIDTH'(1), EXP_MAX);
    send_word(OP_POWER, MOD_WIDTH'(2), EXP_WIDTH'(10));
    send_word(OP_POWER, MOD_RESET, EXP_WIDTH'(3));
    send_word(OP_POWER, MOD_RESET - 1'b1, EXP_WIDTH'(2));
    send_word(OP_POWER, MOD_WIDTH'(12345), EXP_WIDTH'(1));
    send_word(OP_POWER, MOD_WIDTH'(7), EXP_WIDTH'(1) << (EXP_WIDTH - 1));
    send_word(OP_INVERSE, MOD_WIDTH'(2), EXP_MAX);
    send_word(OP_INVERSE, '0, '0);
    send_word(OP_INVERSE, MOD_RESET, EXP_WIDTH'(9));
    send_word(OP_INVERSE, MOD_MAX, '0);
    drain();

    // Smallest usable modulus; inverse of a multiple gives 1 here
    write_modulus(MOD_MIN);
    send_word(OP_INVERSE, MOD_WIDTH'(4), EXP_MAX);
    send_word(OP_POWER, MOD_WIDTH'(3), '0);
    send_word(OP_POWER, MOD_WIDTH'(3), EXP_WIDTH'(7));
    drain();

    // Degenerate moduli: result always zero
    write_modulus('0);
    send_word(OP_POWER, MOD_WIDTH'(5), '0);
    send_word(OP_INVERSE, MOD_MAX, EXP_MAX);
    drain();
    write_modulus(MOD_WIDTH'(1));
    send_word(OP_POWER, '0, '0);
    send_word(OP_INVERSE, MOD_WIDTH'(9), EXP_WIDTH'(3));
    drain();

    // Composite modulus: inverse still forms modulus minus two
    write_modulus(MOD_WIDTH'(1000));
    send_word(OP_INVERSE, MOD_WIDTH'(3), '0);
    send_word(OP_INVERSE, MOD_WIDTH'(2000), '0);
    drain();

    // Random phases across several moduli
    write_modulus(MOD_RESET);
    random_words(20);
    write_modulus(MOD_MAX);
    random_words(20);
    write_modulus(MOD_MIN);
    random_words(15);
    write_modulus(MOD_WIDTH'(3));
    random_words(15);
    write_modulus(MOD_WIDTH'(65537));
    random_words(20);

    // Long output hold with short exponents so the core backs up
    hold_due = 1'b1;
    repeat (5) send_word(OP_POWER, MOD_WIDTH'($urandom()),
                         EXP_WIDTH'($urandom_range(0, 15)), 1'b1);
    drain();

    write_modulus(MOD_WIDTH'($urandom_range(4, 1000)));
    random_words(10);
    write_modulus(MOD_WIDTH'($urandom_range(1 << 20, 32'h7FFF_FFFF)));
    random_words(10);
    write_modulus(MOD_WIDTH'($urandom_range(0, 1)));
    random_words(5);

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d request words (%0d results checked) over %0d modulus writes,",
             sb.words_in, sb.words_checked, mod_settings);
    $display("both opcodes, degenerate moduli and a long output hold.");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
